// File: rtl/core/eup_pkg.sv
package eup_pkg;

  // Status codes reported with each result
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_PROTO  = 3'd2;
  localparam logic [2:0] ST_SYNTAX = 3'd3;
  localparam logic [2:0] ST_LONG   = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Default ports
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_MAX   = 16'hFFFF;

  // Longest scheme ("https") in characters
  localparam logic [2:0] SCHEME_LEN = 3'd5;
  localparam logic [2:0] SCHEME_MIN = 3'd4;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        protocol;
    logic [7:0]  host_start;
    logic [7:0]  host_length;
    logic [15:0] port_value;
    logic        port_given;
  } out_t;

  // Expected scheme character at a given match count
  function automatic logic [7:0] scheme_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h68;  // h
      3'd1:    c = 8'h74;  // t
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h70;  // p
      3'd4:    c = 8'h73;  // s
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/eup_scan.sv
module eup_scan #(
  parameter int MAX_LEN = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  eup_pkg::in_t  item,
  output eup_pkg::out_t res
);
  import eup_pkg::*;

  localparam int PW = $clog2(MAX_LEN + 2);
  localparam logic [PW-1:0] POS_LIM = PW'(MAX_LEN + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN);

  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_SLASH1,
    PH_SLASH2,
    PH_HOST,
    PH_PORT_FIRST,
    PH_PORT,
    PH_PATH
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [2:0]    match_r, match_nxt;
  logic          mismatch_r, mismatch_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    host_off_r, host_off_nxt;
  logic [7:0]    host_len_r, host_len_nxt;
  logic [15:0]   port_r, port_nxt;
  logic          port_seen_r, port_seen_nxt;
  logic [2:0]    err_r, err_nxt;
  logic          secure_r, secure_nxt;

  logic [7:0]    c;
  logic          is_digit;
  logic [20:0]   port_calc;
  logic [2:0]    status;

  assign c         = item.ch;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign port_calc = {2'b00, port_r, 3'b000} + {4'b0000, port_r, 1'b0}
                   + {13'd0, c - CH_ZERO};

  // Update the recognizer state with one byte
  always_comb begin
    phase_nxt     = phase_r;
    match_nxt     = match_r;
    mismatch_nxt  = mismatch_r;
    pos_nxt       = pos_r;
    host_off_nxt  = host_off_r;
    host_len_nxt  = host_len_r;
    port_nxt      = port_r;
    port_seen_nxt = port_seen_r;
    err_nxt       = err_r;
    secure_nxt    = secure_r;
    if (item.has_char) begin
      if (pos_r < POS_LIM) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (err_r == ST_OK) begin
        case (phase_r)
          PH_SCHEME: begin
            if (c == CH_COLON) begin
              if (mismatch_r || match_r < SCHEME_MIN) begin
                err_nxt = ST_PROTO;
              end else begin
                secure_nxt = (match_r == SCHEME_LEN);
                phase_nxt  = PH_SLASH1;
              end
            end else if (match_r < SCHEME_LEN && c == scheme_char(match_r)) begin
              match_nxt = match_r + 1'b1;
            end else begin
              mismatch_nxt = 1'b1;
            end
          end
          PH_SLASH1: begin
            if (c == CH_SLASH) phase_nxt = PH_SLASH2;
            else err_nxt = ST_SYNTAX;
          end
          PH_SLASH2: begin
            if (c == CH_SLASH) begin
              phase_nxt    = PH_HOST;
              host_off_nxt = 8'(pos_r) + 8'd1;
            end else begin
              err_nxt = ST_SYNTAX;
            end
          end
          PH_HOST: begin
            if (c == CH_COLON || c == CH_SLASH) begin
              if (host_len_r == 8'd0) err_nxt = ST_SYNTAX;
              else if (c == CH_COLON) phase_nxt = PH_PORT_FIRST;
              else phase_nxt = PH_PATH;
            end else if (host_len_r != 8'hFF) begin
              host_len_nxt = host_len_r + 8'd1;
            end
          end
          PH_PORT_FIRST: begin
            if (is_digit) begin
              port_nxt      = (port_calc > 21'(PORT_MAX)) ? PORT_MAX : port_calc[15:0];
              port_seen_nxt = 1'b1;
              phase_nxt     = PH_PORT;
            end else begin
              err_nxt = ST_SYNTAX;
            end
          end
          PH_PORT: begin
            if (is_digit) begin
              port_nxt      = (port_calc > 21'(PORT_MAX)) ? PORT_MAX : port_calc[15:0];
              port_seen_nxt = 1'b1;
            end else if (c == CH_SLASH) begin
              phase_nxt = PH_PATH;
            end else begin
              err_nxt = ST_SYNTAX;
            end
          end
          default: begin
            if (c != CH_SLASH) err_nxt = ST_SYNTAX;
          end
        endcase
      end
    end
  end

  // Work out the final status from the updated state
  always_comb begin
    if (pos_nxt == '0) begin
      status = ST_EMPTY;
    end else if (pos_nxt > POS_MAX) begin
      status = ST_LONG;
    end else if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else begin
      case (phase_nxt)
        PH_SCHEME: status = (mismatch_nxt || match_nxt < SCHEME_MIN) ? ST_PROTO : ST_SYNTAX;
        PH_HOST:   status = (host_len_nxt == 8'd0) ? ST_SYNTAX : ST_OK;
        PH_PORT:   status = ST_OK;
        PH_PATH:   status = ST_OK;
        default:   status = ST_SYNTAX;
      endcase
    end
  end

  // Build the result; zero the fields unless the string parsed
  always_comb begin
    res = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.protocol    = secure_nxt;
      res.host_start  = host_off_nxt;
      res.host_length = host_len_nxt;
      res.port_given  = port_seen_nxt;
      if (port_seen_nxt) res.port_value = port_nxt;
      else res.port_value = secure_nxt ? PORT_HTTPS : PORT_HTTP;
    end
  end

  // Hold state; clear it after the last byte of a string
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last)) begin
      phase_r     <= PH_SCHEME;
      match_r     <= '0;
      mismatch_r  <= 1'b0;
      pos_r       <= '0;
      host_off_r  <= '0;
      host_len_r  <= '0;
      port_r      <= '0;
      port_seen_r <= 1'b0;
      err_r       <= ST_OK;
      secure_r    <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      match_r     <= match_nxt;
      mismatch_r  <= mismatch_nxt;
      pos_r       <= pos_nxt;
      host_off_r  <= host_off_nxt;
      host_len_r  <= host_len_nxt;
      port_r      <= port_nxt;
      port_seen_r <= port_seen_nxt;
      err_r       <= err_nxt;
      secure_r    <= secure_nxt;
    end
  end

endmodule

// File: rtl/core/endpoint_url_parser_top.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | in_data  (ch, has_char, last)
// out_    | output    | out_valid / out_ready| out_data (status, protocol, host_start,
//         |           |                      |           host_length, port_value, port_given)
//
// One byte is taken every cycle unless a last byte waits on a stalled result; a result
// is valid once the byte marked last has moved from the input register to the result
// register. The per-byte state update and final check sit between the two registers.
// Reset (rst_n low, synchronous) empties both registers and returns the scan to the scheme.
// A stalled result only holds bytes that carry last; other bytes keep flowing.
module endpoint_url_parser_top #(
  parameter int MAX_LEN = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  eup_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output eup_pkg::out_t out_data
);
  import eup_pkg::*;

  in_t  in_r;
  logic in_v_r;
  out_t out_r;
  logic out_v_r;
  out_t res;
  logic adv;

  // Advance the held byte unless it needs the result slot and that slot is stuck
  assign adv      = in_v_r && (!in_r.last || !out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  eup_scan #(
    .MAX_LEN(MAX_LEN)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .step (adv),
    .item (in_r),
    .res  (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && in_r.last) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_r.last) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
